>>> rtl/core/nwps_pkg.sv
// ----------------------------------------------------------------------------
// nwps_pkg
// shared types and constants of the nearest waypoint selector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nwps_pkg;

   localparam int unsigned PosWidth = 24;
   localparam int unsigned IdxOutWidth = 10;
   localparam int unsigned DistWidth = 51;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   localparam logic signed [15:0] FeatLimit = -16'sd10000;

   // waypoint payload held in the parameter memory
   typedef struct packed {
      logic [15:0] weight;
      logic [7:0]  pause;
      logic [15:0] feat_x;
      logic [15:0] feat_y;
      logic [15:0] leaf_size;
      logic [15:0] meas_range;
      logic [63:0] params;
      logic        signal_triple;
   } wp_data_type;

   typedef struct packed {
      logic [PosWidth-1:0] x;
      logic [PosWidth-1:0] y;
      logic [PosWidth-1:0] z;
   } pos_type;

endpackage

>>> rtl/core/nwps_dist.sv
// ----------------------------------------------------------------------------
// nwps_dist
// registered squared distance between two 3-D positions, two stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nwps_dist (
   input  logic                   clock,
   input  nwps_pkg::pos_type      a,
   input  nwps_pkg::pos_type      b,
   output logic [nwps_pkg::DistWidth-1:0] sq_sum
);
   import nwps_pkg::*;

   logic [PosWidth:0] mx_ff, my_ff, mz_ff;
   logic [2*PosWidth+1:0] sx_ff, sy_ff, sz_ff;

   function automatic logic [PosWidth:0] absdiff(logic [PosWidth-1:0] p,
                                                  logic [PosWidth-1:0] q);
      logic signed [PosWidth:0] d;
      d = $signed({p[PosWidth-1], p}) - $signed({q[PosWidth-1], q});
      absdiff = d[PosWidth] ? (PosWidth+1)'(-d) : d;
   endfunction

   // stage one: magnitudes, stage two: squares
   always_ff @(posedge clock) begin
      mx_ff <= absdiff(a.x, b.x);
      my_ff <= absdiff(a.y, b.y);
      mz_ff <= absdiff(a.z, b.z);
      sx_ff <= mx_ff * mx_ff;
      sy_ff <= my_ff * my_ff;
      sz_ff <= mz_ff * mz_ff;
   end

   assign sq_sum = DistWidth'(sx_ff) + DistWidth'(sy_ff) + DistWidth'(sz_ff);

endmodule

>>> rtl/core/nearest_waypoint_param_select.sv
// ----------------------------------------------------------------------------
// nearest_waypoint_param_select
// waypoint table with linear nearest search and parameter gating
// ----------------------------------------------------------------------------
// channel  direction  content
// req_     in         mode, position and waypoint fields
// rsp_     out        nearest waypoint and gated parameters
//
// clear and append complete at their transfer; a query raises rsp_valid after
// a scan with one read of the position memory per entry, the distance
// pipeline drain and the parameter fetch.
// a query on an empty table gives no result.
// a finished result waits in the output register; the next request is taken
// once the previous result is transferred.
// synchronous reset clears count and last weight and pause; memories not reset.
`timescale 1ns / 1ps

module nearest_waypoint_param_select #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic signed [23:0] req_pos_z,
   input  logic [15:0] req_wp_weight,
   input  logic [7:0]  req_wp_pause,
   input  logic signed [15:0] req_feat_x,
   input  logic signed [15:0] req_feat_y,
   input  logic [15:0] req_leaf_size,
   input  logic [15:0] req_meas_range,
   input  logic [63:0] req_forward_params,
   input  logic        req_signal_triple,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_nearest_index,
   output logic        rsp_param_valid,
   output logic [15:0] rsp_out_weight,
   output logic [63:0] rsp_out_params,
   output logic [7:0]  rsp_out_pause,
   output logic        rsp_adjust_valid,
   output logic signed [15:0] rsp_out_feat_x,
   output logic signed [15:0] rsp_out_feat_y,
   output logic        rsp_voxel_valid,
   output logic [15:0] rsp_out_leaf_size,
   output logic [15:0] rsp_out_meas_range,
   output logic        rsp_signal_valid
);
   import nwps_pkg::*;

   localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned Lat = 4;   // read + two distance stages + compare

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FETCH, ST_DONE} state_type;

   pos_type     pos_mem [TABLE_DEPTH];
   wp_data_type data_mem [TABLE_DEPTH];

   state_type state_ff;
   logic [CntW-1:0] count_ff, rd_ff;
   logic [15:0] last_weight_ff;
   logic [7:0]  last_pause_ff;
   pos_type     query_ff, pos_rd_ff;
   wp_data_type data_rd_ff;
   logic [IdxW-1:0] data_addr;
   logic [Lat-1:0]  vld_ff;
   logic [IdxW-1:0] tag_ff [Lat];
   logic [IdxW-1:0] best_ff;
   logic [DistWidth-1:0] best_d_ff, sq_dist;
   logic first_ff, fetch_ff;
   logic req_fire;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid;
   assign req_fire = req_valid && req_ready;

   // memory writes on append, registered reads of both memories
   always_ff @(posedge clock) begin
      if (req_fire && req_mode == MODE_APPEND && count_ff < CntW'(TABLE_DEPTH)) begin
         pos_mem[count_ff[IdxW-1:0]] <= '{req_pos_x, req_pos_y, req_pos_z};
         data_mem[count_ff[IdxW-1:0]] <= '{req_wp_weight, req_wp_pause, req_feat_x,
            req_feat_y, req_leaf_size, req_meas_range, req_forward_params,
            req_signal_triple};
      end
      pos_rd_ff <= pos_mem[rd_ff[IdxW-1:0]];
      data_rd_ff <= data_mem[data_addr];
   end

   assign data_addr = best_ff;

   nwps_dist u_dist (.clock(clock), .a(pos_rd_ff), .b(query_ff), .sq_sum(sq_dist));

   // control and scan
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         last_weight_ff <= '0;
         last_pause_ff <= '0;
         vld_ff <= '0;
         rsp_valid <= 1'b0;
         rd_ff <= '0;
         fetch_ff <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         vld_ff <= {vld_ff[Lat-2:0], state_ff == ST_SCAN && rd_ff < count_ff};
         tag_ff[0] <= rd_ff[IdxW-1:0];
         for (int k = 1; k < Lat; k++) tag_ff[k] <= tag_ff[k-1];
         // compare stage: sq_dist aligns with tag_ff[Lat-2]
         if (vld_ff[Lat-2]) begin
            first_ff <= 1'b0;
            if (first_ff || sq_dist < best_d_ff) begin
               best_d_ff <= sq_dist;
               best_ff <= tag_ff[Lat-2];
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (mode_type'(req_mode))
                     MODE_CLEAR: count_ff <= '0;
                     MODE_APPEND:
                        if (count_ff < CntW'(TABLE_DEPTH)) count_ff <= count_ff + 1'b1;
                     MODE_QUERY:
                        if (count_ff != '0) begin
                           query_ff <= '{req_pos_x, req_pos_y, req_pos_z};
                           rd_ff <= '0;
                           first_ff <= 1'b1;
                           state_ff <= ST_SCAN;
                        end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               if (rd_ff < count_ff) rd_ff <= rd_ff + 1'b1;
               else if (vld_ff == '0) state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               fetch_ff <= !fetch_ff;
               if (fetch_ff) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               rsp_valid <= 1'b1;
               rsp_nearest_index <= IdxOutWidth'(best_ff);
               rsp_out_weight <= data_rd_ff.weight;
               last_weight_ff <= data_rd_ff.weight;
               rsp_param_valid <= data_rd_ff.weight == last_weight_ff;
               if (data_rd_ff.weight == last_weight_ff) begin
                  rsp_out_params <= data_rd_ff.params;
                  rsp_out_pause <= (data_rd_ff.pause != last_pause_ff) ?
                                   data_rd_ff.pause : 8'd0;
                  last_pause_ff <= data_rd_ff.pause;
                  rsp_adjust_valid <= $signed(data_rd_ff.feat_x) > FeatLimit;
                  rsp_out_feat_x <= data_rd_ff.feat_x;
                  rsp_out_feat_y <= data_rd_ff.feat_y;
                  rsp_voxel_valid <= data_rd_ff.leaf_size != 16'd0;
                  rsp_out_leaf_size <= data_rd_ff.leaf_size;
                  rsp_out_meas_range <= data_rd_ff.meas_range;
                  rsp_signal_valid <= data_rd_ff.signal_triple;
               end else begin
                  rsp_out_params <= '0;
                  rsp_out_pause <= '0;
                  rsp_adjust_valid <= 1'b0;
                  rsp_out_feat_x <= '0;
                  rsp_out_feat_y <= '0;
                  rsp_voxel_valid <= 1'b0;
                  rsp_out_leaf_size <= '0;
                  rsp_out_meas_range <= '0;
                  rsp_signal_valid <= 1'b0;
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
